FILE: sv/assert_macros.svh
// Assertion helpers included by the checker in sv/bole_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge, skipped during reset
`define CHK_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every rising clock edge, reset included
`define CHK_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/bole_pkg.sv
package bole_pkg;

   localparam int CAPACITY_DEF    = 16;
   localparam int VALUE_WIDTH_DEF = 32;

   localparam logic [2:0] OP_INS_FRONT = 3'd0;
   localparam logic [2:0] OP_INS_BACK  = 3'd1;
   localparam logic [2:0] OP_FIND      = 3'd2;
   localparam logic [2:0] OP_UPDATE    = 3'd3;
   localparam logic [2:0] OP_REMOVE    = 3'd4;
   localparam logic [2:0] OP_CLEAR     = 3'd5;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NOTFOUND = 2'd1;
   localparam logic [1:0] ST_FULL     = 2'd2;

   // controller -> datapath
   typedef struct packed {
      logic load;     // capture request
      logic execute;  // apply operation to cells
   } dp_cmd_type;

endpackage

FILE: sv/bole_datapath.sv
module bole_datapath
   import bole_pkg::*;
#(
   parameter int CAPACITY    = CAPACITY_DEF,
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  dp_cmd_type                  cmd,
   input  logic [2:0]                  req_type,
   input  logic signed [31:0]          key,
   input  logic signed [31:0]          new_value,
   output logic [1:0]                  status,
   output logic [3:0]                  position,
   output logic [4:0]                  entry_count
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int IW = $clog2(CAPACITY);

   logic [VALUE_WIDTH-1:0] cell_ff [CAPACITY];
   logic [CW-1:0]          count_ff, count_in;
   logic [2:0]             op_ff;
   logic [VALUE_WIDTH-1:0] key_ff, nv_ff;
   logic [CAPACITY-1:0]    hit_ff;
   logic [1:0]             status_ff, status_in;
   logic [3:0]             pos_ff, pos_in;
   logic [IW-1:0]          m_idx;
   logic                   m_any;
   logic [CAPACITY-1:0]    hit_in;

   // parallel compare of every live cell
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         hit_in[i] = (CW'(i) < count_ff) &&
                     (cell_ff[i] == VALUE_WIDTH'(signed'(key)));
      end
   end

   // priority encode the registered hits
   always_comb begin
      m_idx = '0;
      m_any = 1'b0;
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (hit_ff[i]) begin
            m_idx = IW'(i);
            m_any = 1'b1;
         end
      end
   end

   always_comb begin
      count_in  = count_ff;
      status_in = ST_OK;
      pos_in    = '0;
      case (op_ff)
         OP_INS_FRONT, OP_INS_BACK: begin
            if (count_ff >= CW'(CAPACITY)) begin
               status_in = ST_FULL;
            end else begin
               count_in = count_ff + 1'b1;
               if (op_ff == OP_INS_BACK) pos_in = 4'(count_ff);
            end
         end
         OP_FIND, OP_UPDATE, OP_REMOVE: begin
            if (!m_any) begin
               status_in = ST_NOTFOUND;
            end else begin
               pos_in = 4'(m_idx);
               if (op_ff == OP_REMOVE) count_in = count_ff - 1'b1;
            end
         end
         OP_CLEAR: count_in = '0;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= req_type;
         key_ff <= VALUE_WIDTH'(signed'(key));
         nv_ff  <= VALUE_WIDTH'(signed'(new_value));
         hit_ff <= hit_in;
      end
      if (cmd.execute) begin
         status_ff <= status_in;
         pos_ff    <= pos_in;
         for (int i = 0; i < CAPACITY; i++) begin
            case (op_ff)
               OP_INS_FRONT: if (count_ff < CW'(CAPACITY)) begin
                  cell_ff[i] <= (i == 0) ? key_ff : cell_ff[(i == 0) ? 0 : i - 1];
               end
               OP_INS_BACK: if (count_ff < CW'(CAPACITY) && CW'(i) == count_ff) begin
                  cell_ff[i] <= key_ff;
               end
               OP_UPDATE: if (m_any && IW'(i) == m_idx) cell_ff[i] <= nv_ff;
               OP_REMOVE: if (m_any && IW'(i) >= m_idx && i < CAPACITY - 1) begin
                  cell_ff[i] <= cell_ff[(i < CAPACITY - 1) ? i + 1 : i];
               end
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) count_ff <= '0;
      else if (cmd.execute) count_ff <= count_in;
   end

   assign status      = status_ff;
   assign position    = pos_ff;
   assign entry_count = 5'(count_ff);

endmodule

FILE: sv/bole_control.sv
module bole_control
   import bole_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output dp_cmd_type cmd
);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_EXEC = 3'b010,
      S_RESP = 3'b100
   } state_type;

   state_type state_ff, state_in;

   assign req_stall   = (state_ff != S_IDLE);
   assign rsp_valid   = (state_ff == S_RESP);
   assign cmd.load    = (state_ff == S_IDLE) && req_valid;
   assign cmd.execute = (state_ff == S_EXEC);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (req_valid) state_in = S_EXEC;
         S_EXEC: state_in = S_RESP;
         S_RESP: if (!rsp_stall) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

endmodule

FILE: sv/bounded_ordered_list_engine.sv
// Ordered list of up to CAPACITY values held in a row of cells. A request is
// taken (key compared against every live cell at once), applied in the next
// cycle (cells shift or overwrite in one step), and its result is then offered
// until it is taken, through any output stall; one request is handled at a
// time. req_stall is high from acceptance until the result is taken.
module bounded_ordered_list_engine
   import bole_pkg::*;
#(
   parameter int CAPACITY    = CAPACITY_DEF,
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_type,
   input  logic signed [31:0] req_key,
   input  logic signed [31:0] req_new_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_status,
   output logic [3:0]         rsp_position,
   output logic [4:0]         rsp_entry_count
);

   dp_cmd_type cmd;

   bole_control u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall, .cmd
   );

   bole_datapath #(.CAPACITY(CAPACITY), .VALUE_WIDTH(VALUE_WIDTH)) u_dp (
      .clock, .reset, .cmd,
      .req_type, .key(req_key), .new_value(req_new_value),
      .status(rsp_status), .position(rsp_position), .entry_count(rsp_entry_count)
   );

endmodule

FILE: sv/bole_checker.sv
`include "assert_macros.svh"

module bole_assertions
   import bole_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [1:0] rsp_status,
   input logic [3:0] rsp_position,
   input logic [4:0] rsp_entry_count
);

   `CHK_CLK(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable({rsp_status, rsp_position, rsp_entry_count}), "result changed while stalled")
   `CHK_CLK(a_one_at_a_time, clock, reset, rsp_valid |-> req_stall, "request taken with result pending")
   `CHK_CLK(a_accept_to_rsp, clock, reset, req_valid && !req_stall |=> ##1 rsp_valid, "result not offered two cycles after accept")
   `CHK_CLK(a_status_code, clock, reset, rsp_valid |-> rsp_status <= ST_FULL, "bad status code")
   `CHK_ALWAYS(a_reset_idle, clock, reset |=> !rsp_valid, "result after reset")

endmodule

bind bounded_ordered_list_engine bole_assertions u_chk (
   .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall,
   .rsp_status, .rsp_position, .rsp_entry_count
);

FILE: bench/bole_checker.sv
`timescale 1ns / 1ps
module bole_checker
   import bole_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [2:0]         req_type,
   input  logic signed [31:0] req_key,
   input  logic signed [31:0] req_new_value,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic [1:0]         rsp_status,
   input  logic [3:0]         rsp_position,
   input  logic [4:0]         rsp_entry_count,
   output int                 fail_count,
   output int                 pending
);

   typedef struct packed {
      logic [1:0] status;
      logic [3:0] position;
      logic [4:0] count;
   } outcome_t;

   logic [31:0] list_vals [CAPACITY_DEF];
   int          list_len;
   outcome_t    outcome_q [$];

   function automatic int find_first(logic [31:0] v);
      for (int i = 0; i < list_len; i++)
         if (list_vals[i] == v) return i;
      return -1;
   endfunction

   function automatic outcome_t apply_request(logic [2:0] op, logic [31:0] k,
                                               logic [31:0] nv);
      outcome_t o;
      int       m;
      o = '0;
      case (op)
         OP_INS_FRONT, OP_INS_BACK: begin
            if (list_len >= CAPACITY_DEF) begin
               o.status = ST_FULL;
            end else if (op == OP_INS_FRONT) begin
               for (int i = list_len; i > 0; i--) list_vals[i] = list_vals[i-1];
               list_vals[0] = k;
               list_len++;
            end else begin
               list_vals[list_len] = k;
               o.position = list_len[3:0];
               list_len++;
            end
         end
         OP_FIND, OP_UPDATE, OP_REMOVE: begin
            m = find_first(k);
            if (m < 0) begin
               o.status = ST_NOTFOUND;
            end else begin
               o.position = m[3:0];
               if (op == OP_UPDATE) list_vals[m] = nv;
               else if (op == OP_REMOVE) begin
                  for (int i = m; i + 1 < list_len; i++) list_vals[i] = list_vals[i+1];
                  list_len--;
               end
            end
         end
         OP_CLEAR: list_len = 0;
         default: ;
      endcase
      o.count = list_len[4:0];
      return o;
   endfunction

   assign pending = outcome_q.size();

   always @(posedge clock) begin
      outcome_t want;
      if (reset) begin
         list_len = 0;
         outcome_q.delete();
         fail_count = 0;
      end else begin
         if (req_valid && !req_stall)
            outcome_q.push_back(apply_request(req_type, req_key, req_new_value));
         if (rsp_valid && !rsp_stall) begin
            if (outcome_q.size() == 0) begin
               $display("%0t: unexpected result st=%0d pos=%0d cnt=%0d", $time,
                        rsp_status, rsp_position, rsp_entry_count);
               fail_count++;
            end else begin
               want = outcome_q.pop_front();
               if (rsp_status !== want.status) begin
                  $display("%0t: status expected %0d actual %0d", $time,
                           want.status, rsp_status);
                  fail_count++;
               end
               if (rsp_position !== want.position) begin
                  $display("%0t: position expected %0d actual %0d", $time,
                           want.position, rsp_position);
                  fail_count++;
               end
               if (rsp_entry_count !== want.count) begin
                  $display("%0t: entry_count expected %0d actual %0d", $time,
                           want.count, rsp_entry_count);
                  fail_count++;
               end
            end
         end
      end
   end

endmodule

FILE: bench/tb_bounded_ordered_list_engine.sv
`timescale 1ns / 1ps
module tb_bounded_ordered_list_engine;
   import bole_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;

   logic               clock = 0;
   logic               reset = 1;
   logic               req_valid = 0;
   logic               req_stall;
   logic [2:0]         req_type = '0;
   logic signed [31:0] req_key = '0;
   logic signed [31:0] req_new_value = '0;
   logic               rsp_valid;
   logic               rsp_stall = 0;
   logic [1:0]         rsp_status;
   logic [3:0]         rsp_position;
   logic [4:0]         rsp_entry_count;
   int                 fail_count;
   int                 pending;
   int                 send_idle_pct = 0;
   int                 stall_pct = 0;
   int                 hold_off = 0;
   int                 quiet_cycles = 0;
   logic [31:0]        pool [8];

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   bounded_ordered_list_engine dut (.*);

   bole_checker chk (.*);

   always @(posedge clock) begin
      if (hold_off > 0) begin
         rsp_stall <= 1;
         hold_off  <= hold_off - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("** bounded_ordered_list_engine: FAILED **");
         $finish;
      end
   end

   // valid stays high after acceptance until the next item or an idle cycle
   task automatic offer(logic [2:0] op, logic [31:0] k, logic [31:0] nv);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid     <= 1;
      req_type      <= op;
      req_key       <= k;
      req_new_value <= nv;
      do @(posedge clock); while (req_stall);
   endtask

   // keys mostly from a small pool so finds and removes hit
   function automatic logic [31:0] pick_key();
      case ($urandom_range(3))
         0:       return $urandom;
         1:       return {1'($urandom_range(1)), {31{1'($urandom_range(1))}}};
         default: return pool[$urandom_range(7)];
      endcase
   endfunction

   task automatic random_items(int n);
      int r;
      logic [2:0] op;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(99);
         if (r < 22)      op = OP_INS_BACK;
         else if (r < 40) op = OP_INS_FRONT;
         else if (r < 58) op = OP_FIND;
         else if (r < 72) op = OP_UPDATE;
         else if (r < 92) op = OP_REMOVE;
         else if (r < 95) op = OP_CLEAR;
         else             op = 3'($urandom_range(7));
         offer(op, pick_key(), $urandom_range(1) ? pool[$urandom_range(7)] : $urandom);
      end
   endtask

   initial begin
      for (int i = 0; i < 8; i++) pool[i] = $urandom;
      pool[0] = 32'h8000_0000;
      pool[1] = 32'h7FFF_FFFF;
      pool[2] = '0;
      pool[3] = '1;
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // empty list, then fill past full, probe the full list and unused opcodes, then clear
      offer(OP_FIND, '0, '0);
      offer(OP_REMOVE, '1, '0);
      offer(OP_UPDATE, '0, '1);
      offer(OP_INS_FRONT, 32'h8000_0000, '0);
      offer(OP_INS_BACK, 32'h7FFF_FFFF, '0);
      for (int i = 0; i < 15; i++) offer(OP_INS_BACK, i[0] ? '1 : 32'h5555_AAAA, '0);
      offer(OP_INS_FRONT, '0, '0);
      offer(OP_FIND, '1, '0);
      offer(OP_UPDATE, 32'h7FFF_FFFF, 32'hAAAA_5555);
      offer(OP_REMOVE, 32'h8000_0000, '0);
      offer(3'd6, '0, '0);
      offer(3'd7, '1, '1);
      offer(OP_CLEAR, '0, '0);

      random_items(450);
      send_idle_pct = 87;
      random_items(400);
      send_idle_pct = 0;
      stall_pct = 87;
      random_items(400);
      send_idle_pct = 18;
      stall_pct = 18;
      hold_off <= 300;
      random_items(520);
      req_valid <= 0;

      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0)
         $display("** bounded_ordered_list_engine: PASSED **");
      else
         $display("** bounded_ordered_list_engine: FAILED **");
      $finish;
   end

endmodule
